### rtl/psrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared types, constants and register codes of the span run setup block.
// ----------------------------------------------------------------------------
package psrs_pkg;

  localparam int RunPixels  = 16;
  localparam int MaxSpan    = 1024;
  localparam int MaxResults = 64;
  localparam int SpanCap    = (MaxSpan < MaxResults * RunPixels) ? MaxSpan
                                                                 : MaxResults * RunPixels;
  localparam int RunW       = $clog2(RunPixels + 1);
  localparam int CmdDepth   = 4;
  localparam int CmdPtrW    = $clog2(CmdDepth);
  localparam int DivN       = 47;
  localparam int DivCntW    = $clog2(DivN);
  localparam logic [31:0] ZSatLimit = 32'd32768;
  localparam logic [30:0] ZSat      = 31'h7FFF_FFFF;

  typedef enum logic [7:0] {
    CFG_S_STEP    = 8'd0,
    CFG_T_STEP    = 8'd1,
    CFG_IZ_STEP   = 8'd2,
    CFG_S_BIAS    = 8'd3,
    CFG_T_BIAS    = 8'd4,
    CFG_S_LIMIT   = 8'd5,
    CFG_T_LIMIT   = 8'd6,
    CFG_ROW_PITCH = 8'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] s_over_z_step_x;
    logic [31:0] t_over_z_step_x;
    logic [31:0] inv_z_step_x;
    logic [31:0] s_bias;
    logic [31:0] t_bias;
    logic [30:0] s_limit;
    logic [30:0] t_limit;
    logic [12:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    logic [9:0]         start_x;
    logic [9:0]         start_y;
    logic [10:0]        span_len;
    logic signed [31:0] s_over_z_start;
    logic signed [31:0] t_over_z_start;
    logic [31:0]        inv_z_start;
  } in_t;

  typedef struct packed {
    logic [21:0]        dest_offset;
    logic [30:0]        s_begin;
    logic [30:0]        t_begin;
    logic signed [31:0] s_delta;
    logic signed [31:0] t_delta;
    logic [4:0]         run_len;
    logic               last;
  } out_t;

  typedef struct packed {
    logic            first;
    logic [RunW-1:0] run;
    logic [RunW-1:0] adv;
    logic            last;
    logic [21:0]     dest_offset;
    logic [31:0]     sdivz;
    logic [31:0]     tdivz;
    logic [31:0]     zi;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ADV,
    BK_ZDIV,
    BK_PMUL,
    BK_PCLAMP,
    BK_SDIV,
    BK_TDIV,
    BK_EMIT
  } back_state_e;

endpackage

### rtl/psrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psrs_div
  import psrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DivN-1:0]  dividend_i,
  input  logic [31:0]      divisor_i,
  output logic             done_o,
  output logic [DivN-1:0]  quot_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [31:0]        rem_q, rem_d;
  logic [DivN-1:0]    quo_q, quo_d;
  logic [31:0]        dvs_q, dvs_d;
  logic [32:0]        trial;

  assign trial = {rem_q, quo_q[DivN-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (!busy_q) begin
      if (go_i) begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = '0;
        quo_d  = dividend_i;
        dvs_d  = divisor_i;
      end
    end else begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DivN-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[DivN-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivN - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/psrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_front
// Accepts spans and cuts them into run commands for the back end.
// ----------------------------------------------------------------------------
module psrs_front
  import psrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_i,
  input  logic [12:0] row_pitch_i,
  output logic        cmd_push_o,
  input  logic        cmd_full_i,
  output cmd_t        cmd_o
);

  logic        busy_q, busy_d;
  logic        first_q, first_d;
  logic [10:0] left_q, left_d;
  logic [10:0] off_q, off_d;
  logic [21:0] base_q, base_d;
  in_t         span_q, span_d;
  logic [10:0] len_clamped;
  logic [10:0] run;
  logic        accept;

  assign full       = busy_q;
  assign accept     = push && !busy_q;
  assign cmd_push_o = busy_q && !cmd_full_i;

  assign len_clamped = (32'(in_i.span_len) > SpanCap) ? 11'(SpanCap) : in_i.span_len;
  assign run         = (left_q >= 11'(RunPixels)) ? 11'(RunPixels) : left_q;

  always_comb begin
    cmd_o.first       = first_q;
    cmd_o.run         = RunW'(run);
    cmd_o.adv         = (left_q >= 11'(RunPixels)) ? RunW'(RunPixels) : RunW'(left_q - 11'd1);
    cmd_o.last        = (left_q == run);
    cmd_o.dest_offset = 22'(base_q + 22'(off_q));
    cmd_o.sdivz       = span_q.s_over_z_start;
    cmd_o.tdivz       = span_q.t_over_z_start;
    cmd_o.zi          = span_q.inv_z_start;
  end

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    left_d  = left_q;
    off_d   = off_q;
    base_d  = base_q;
    span_d  = span_q;
    if (accept) begin
      busy_d  = (len_clamped != 11'd0);
      first_d = 1'b1;
      left_d  = len_clamped;
      off_d   = '0;
      base_d  = 22'(23'(in_i.start_y) * 23'(row_pitch_i) + 23'(in_i.start_x));
      span_d  = in_i;
    end else if (cmd_push_o) begin
      first_d = 1'b0;
      left_d  = left_q - run;
      off_d   = off_q + run;
      if (left_q == run) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      left_q  <= '0;
      off_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      left_q  <= left_d;
      off_q   <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    span_q <= span_d;
  end

endmodule

### rtl/psrs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module psrs_fifo
  import psrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_q, rd_q;
  logic [CmdPtrW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CmdPtrW+1)'(CmdDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (CmdPtrW+1)'(do_push) - (CmdPtrW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/psrs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_back
// Runs each command: interpolation, reciprocal, projection, step divides.
// ----------------------------------------------------------------------------
module psrs_back
  import psrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_empty_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic out_valid_o,
  output out_t out_o,
  input  logic out_pop_i
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic        init_q, div_run_q;
  logic [31:0] sdivz_q, tdivz_q, zi_q;
  logic [30:0] z_q, s_q, t_q, snext_q, tnext_q;
  logic [31:0] prod_s_q, prod_t_q, ds_q, dt_q;
  logic        out_valid_q;
  out_t        out_q;

  logic            div_go, div_done;
  logic [DivN-1:0] div_dividend, div_quot;
  logic [31:0]     div_divisor;
  logic            out_free;
  logic [31:0]     diff_s, diff_t, mag_s, mag_t, quot_signed;
  logic [31:0]     sh_s, sh_t;
  logic [30:0]     clamp_s, clamp_t;

  function automatic logic [30:0] clamp_coord(input logic [31:0] v, input logic [30:0] lim);
    logic [30:0] r;
    if (v[31]) r = '0;
    else if (v[30:0] > lim) r = lim;
    else r = v[30:0];
    return r;
  endfunction

  assign out_free = !out_valid_q || out_pop_i;

  assign diff_s = {1'b0, snext_q} - {1'b0, s_q};
  assign diff_t = {1'b0, tnext_q} - {1'b0, t_q};
  assign mag_s  = diff_s[31] ? -diff_s : diff_s;
  assign mag_t  = diff_t[31] ? -diff_t : diff_t;

  assign sh_s = $signed(sdivz_q) >>> 4;
  assign sh_t = $signed(tdivz_q) >>> 4;
  assign clamp_s = clamp_coord(prod_s_q + cfg_i.s_bias, cfg_i.s_limit);
  assign clamp_t = clamp_coord(prod_t_q + cfg_i.t_bias, cfg_i.t_limit);

  always_comb begin
    case (state_q)
      BK_SDIV: quot_signed = diff_s[31] ? -div_quot[31:0] : div_quot[31:0];
      default: quot_signed = diff_t[31] ? -div_quot[31:0] : div_quot[31:0];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) state_d = cmd_i.first ? BK_ZDIV : BK_ADV;
      end
      BK_ADV:    state_d = BK_ZDIV;
      BK_ZDIV:   if (div_done) state_d = BK_PMUL;
      BK_PMUL:   state_d = BK_PCLAMP;
      BK_PCLAMP: state_d = init_q ? BK_ADV : BK_SDIV;
      BK_SDIV:   if (div_done) state_d = BK_TDIV;
      BK_TDIV:   if (div_done) state_d = BK_EMIT;
      BK_EMIT:   if (out_free) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // outputs to the divider and the command queue
  always_comb begin
    cmd_pop_o    = 1'b0;
    div_go       = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      BK_IDLE: cmd_pop_o = !cmd_empty_i;
      BK_ZDIV: begin
        div_go       = !div_run_q;
        div_dividend = DivN'(1) << (DivN - 1);
        div_divisor  = zi_q;
      end
      BK_SDIV: begin
        div_go       = !div_run_q;
        div_dividend = DivN'(mag_s);
        div_divisor  = 32'(cmd_q.run);
      end
      BK_TDIV: begin
        div_go       = !div_run_q;
        div_dividend = DivN'(mag_t);
        div_divisor  = 32'(cmd_q.run);
      end
      default: ;
    endcase
  end

  psrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_go) div_run_q <= 1'b1;
      else if (div_done) div_run_q <= 1'b0;
      if (state_q == BK_EMIT && out_free) out_valid_q <= 1'b1;
      else if (out_pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        cmd_q  <= cmd_i;
        init_q <= cmd_i.first;
        if (cmd_i.first) begin
          sdivz_q <= cmd_i.sdivz;
          tdivz_q <= cmd_i.tdivz;
          zi_q    <= cmd_i.zi;
        end
      end
      BK_ADV: begin
        init_q  <= 1'b0;
        sdivz_q <= sdivz_q + 32'(cfg_i.s_over_z_step_x * 32'(cmd_q.adv));
        tdivz_q <= tdivz_q + 32'(cfg_i.t_over_z_step_x * 32'(cmd_q.adv));
        zi_q    <= zi_q + 32'(cfg_i.inv_z_step_x * 32'(cmd_q.adv));
      end
      BK_ZDIV: begin
        if (div_done) z_q <= (zi_q <= ZSatLimit) ? ZSat : div_quot[30:0];
      end
      BK_PMUL: begin
        prod_s_q <= 32'(sh_s * {13'b0, z_q[30:12]});
        prod_t_q <= 32'(sh_t * {13'b0, z_q[30:12]});
      end
      BK_PCLAMP: begin
        if (init_q) begin
          s_q <= clamp_s;
          t_q <= clamp_t;
        end else begin
          snext_q <= clamp_s;
          tnext_q <= clamp_t;
        end
      end
      BK_SDIV: if (div_done) ds_q <= quot_signed;
      BK_TDIV: if (div_done) dt_q <= quot_signed;
      BK_EMIT: begin
        if (out_free) begin
          out_q.dest_offset <= cmd_q.dest_offset;
          out_q.s_begin     <= s_q;
          out_q.t_begin     <= t_q;
          out_q.s_delta     <= ds_q;
          out_q.t_delta     <= dt_q;
          out_q.run_len     <= 5'(cmd_q.run);
          out_q.last        <= cmd_q.last;
          // next run starts where the stepped coordinate lands
          s_q <= 31'({1'b0, s_q} + 32'(ds_q * 32'(cmd_q.run)));
          t_q <= 31'({1'b0, t_q} + 32'(dt_q * 32'(cmd_q.run)));
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/perspective_span_run_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_span_run_setup
// Cuts a screen span into affine texture runs with perspective-correct ends.
// ----------------------------------------------------------------------------
// Input side is a queue: a span transaction is taken when push is high and
// full is low. Full stays high while the front end is still cutting the
// current span into run commands (one command a cycle while the four-entry
// queue has room). Results come out as a queue: the oldest run waits on
// out_o while empty is low and leaves when pop is high.
// Configuration writes go through cfg_valid_i/cfg_ready_o; ready is always
// high, and the registers are to be written only while the block is idle.
// In the back end each run takes three passes through the shared bit-serial
// divider (reciprocal of 1/z, then s and t steps), one run at a time. A span
// adds an extra reciprocal and projection at its start, for the first run.
// A zero-length span is taken and yields nothing.
// When the receiver stalls, the back end finishes its current run, holds it
// until the output register is free, and the queue and front end back up.
// Reset clears the control state and loads the register defaults (row
// pitch 320, everything else zero).
// ----------------------------------------------------------------------------
module perspective_span_run_setup
  import psrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_i,
  output logic        empty,
  input  logic        pop,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty, out_valid;
  cmd_t cmd_wr, cmd_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.s_over_z_step_x <= '0;
      cfg_q.t_over_z_step_x <= '0;
      cfg_q.inv_z_step_x    <= '0;
      cfg_q.s_bias          <= '0;
      cfg_q.t_bias          <= '0;
      cfg_q.s_limit         <= '0;
      cfg_q.t_limit         <= '0;
      cfg_q.row_pitch       <= 13'd320;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_S_STEP:    cfg_q.s_over_z_step_x <= cfg_data_i;
        CFG_T_STEP:    cfg_q.t_over_z_step_x <= cfg_data_i;
        CFG_IZ_STEP:   cfg_q.inv_z_step_x    <= cfg_data_i;
        CFG_S_BIAS:    cfg_q.s_bias          <= cfg_data_i;
        CFG_T_BIAS:    cfg_q.t_bias          <= cfg_data_i;
        CFG_S_LIMIT:   cfg_q.s_limit         <= cfg_data_i[30:0];
        CFG_T_LIMIT:   cfg_q.t_limit         <= cfg_data_i[30:0];
        CFG_ROW_PITCH: cfg_q.row_pitch       <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  psrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .row_pitch_i (cfg_q.row_pitch),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full),
    .cmd_o       (cmd_wr)
  );

  psrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_rd)
  );

  psrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid),
    .out_o       (out_o),
    .out_pop_i   (pop)
  );

  assign empty = !out_valid;

endmodule

### rtl/psrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrs_checker
// Port-level checks on the run stream, bound to the top level.
// ----------------------------------------------------------------------------
module psrs_checker
  import psrs_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic empty,
  input logic pop,
  input out_t out_o
);

  // a waiting run holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_o)))
    else $error("waiting run changed before pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.run_len != 5'd0 && 32'(out_o.run_len) <= RunPixels))
    else $error("run length out of range");

  // only the final run of a span may be short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.last) |-> (32'(out_o.run_len) == RunPixels))
    else $error("short run not flagged last");

endmodule

bind perspective_span_run_setup psrs_checker u_psrs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Span run setup regression: drives span transactions and register writes,
// predicts every run of each span in a scoreboard and checks the run queue.
// ----------------------------------------------------------------------------

class SpanRunBoard;
  psrs_pkg::out_t   run_q[$];
  logic [31:0]      s_step, t_step, iz_step, s_bias, t_bias;
  logic [30:0]      s_lim, t_lim;
  logic [12:0]      pitch;
  int               errors;

  function new();
    s_step = '0; t_step = '0; iz_step = '0; s_bias = '0; t_bias = '0;
    s_lim = '0; t_lim = '0; pitch = 13'd320; errors = 0;
  endfunction

  function void set_reg(psrs_pkg::cfg_idx_e idx, logic [31:0] d);
    case (idx)
      psrs_pkg::CFG_S_STEP:    s_step  = d;
      psrs_pkg::CFG_T_STEP:    t_step  = d;
      psrs_pkg::CFG_IZ_STEP:   iz_step = d;
      psrs_pkg::CFG_S_BIAS:    s_bias  = d;
      psrs_pkg::CFG_T_BIAS:    t_bias  = d;
      psrs_pkg::CFG_S_LIMIT:   s_lim   = d[30:0];
      psrs_pkg::CFG_T_LIMIT:   t_lim   = d[30:0];
      psrs_pkg::CFG_ROW_PITCH: pitch   = d[12:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] depth_of(logic [31:0] iz);
    logic [63:0] q;
    if (iz == 32'd0) return 32'h7FFF_FFFF;
    q = (64'd1 << 46) / {32'd0, iz};
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function logic [31:0] tex_coord(logic [30:0] lim, logic [31:0] divz, logic [31:0] z,
                                  logic [31:0] bias);
    logic signed [31:0] sh;
    logic [31:0]        prod;
    logic signed [31:0] v;
    sh   = $signed(divz) >>> 4;
    prod = sh * (z >> 12);
    v    = prod + bias;
    if (v < 0) return '0;
    if (v > $signed({1'b0, lim})) return {1'b0, lim};
    return v;
  endfunction

  // cut one span into its runs and queue them
  function void note(psrs_pkg::in_t sp);
    logic [31:0] sdz, tdz, izv, z, s, t, sn, tn, off, left, run, adv;
    longint      ds, dt;
    psrs_pkg::out_t r;
    sdz = sp.s_over_z_start; tdz = sp.t_over_z_start; izv = sp.inv_z_start;
    left = 32'(sp.span_len); off = '0;
    if (left > psrs_pkg::SpanCap) left = 32'(psrs_pkg::SpanCap);
    if (left == 32'd0) return;
    z = depth_of(izv);
    s = tex_coord(s_lim, sdz, z, s_bias);
    t = tex_coord(t_lim, tdz, z, t_bias);
    while (left > 32'd0) begin
      if (left >= psrs_pkg::RunPixels) begin
        run = 32'(psrs_pkg::RunPixels); adv = 32'(psrs_pkg::RunPixels);
      end else begin
        run = left; adv = left - 32'd1;
      end
      sdz = sdz + s_step * adv;
      tdz = tdz + t_step * adv;
      izv = izv + iz_step * adv;
      z  = depth_of(izv);
      sn = tex_coord(s_lim, sdz, z, s_bias);
      tn = tex_coord(t_lim, tdz, z, t_bias);
      ds = (longint'(sn) - longint'(s)) / longint'(run);
      dt = (longint'(tn) - longint'(t)) / longint'(run);
      r.dest_offset = 22'(32'(sp.start_y) * 32'(pitch) + 32'(sp.start_x) + off);
      r.s_begin = s[30:0];
      r.t_begin = t[30:0];
      r.s_delta = ds[31:0];
      r.t_delta = dt[31:0];
      r.run_len = run[4:0];
      r.last    = (left == run);
      run_q.push_back(r);
      s = 32'(longint'(s) + ds * longint'(run));
      t = 32'(longint'(t) + dt * longint'(run));
      off  = off + run;
      left = left - run;
    end
  endfunction

  function void check(psrs_pkg::out_t got);
    psrs_pkg::out_t exp_r;
    if (run_q.size() == 0) begin
      $display("%0t: unexpected run %h", $time, got);
      errors++;
      return;
    end
    exp_r = run_q.pop_front();
    if (got.dest_offset !== exp_r.dest_offset) begin
      $display("%0t: dest_offset exp %h got %h", $time, exp_r.dest_offset, got.dest_offset);
      errors++;
    end
    if (got.s_begin !== exp_r.s_begin) begin
      $display("%0t: s_begin exp %h got %h", $time, exp_r.s_begin, got.s_begin);
      errors++;
    end
    if (got.t_begin !== exp_r.t_begin) begin
      $display("%0t: t_begin exp %h got %h", $time, exp_r.t_begin, got.t_begin);
      errors++;
    end
    if (got.s_delta !== exp_r.s_delta) begin
      $display("%0t: s_delta exp %h got %h", $time, exp_r.s_delta, got.s_delta);
      errors++;
    end
    if (got.t_delta !== exp_r.t_delta) begin
      $display("%0t: t_delta exp %h got %h", $time, exp_r.t_delta, got.t_delta);
      errors++;
    end
    if (got.run_len !== exp_r.run_len) begin
      $display("%0t: run_len exp %0d got %0d", $time, exp_r.run_len, got.run_len);
      errors++;
    end
    if (got.last !== exp_r.last) begin
      $display("%0t: last exp %b got %b", $time, exp_r.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import psrs_pkg::*;

  localparam int CycleLimit = 40_000_000;
  localparam int DrainWait  = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_t         in_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_t        out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  SpanRunBoard board = new();
  int          cycles = 0;
  int          pops = 0;

  perspective_span_run_setup uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: every popped run goes to the scoreboard
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      board.check(out_o);
      pops <= pops + 1;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // receiver: random stalls plus one long hold-off to fill the block up
  initial begin : receiver
    int  n;
    bit  held;
    held = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && pops >= 60) begin
        held = 1;
        pop <= 1'b0;
        repeat (4000) @(posedge clk_i);
      end
      n = gap_len();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  task automatic send_span(in_t v);
    int n;
    push <= 1'b1;
    in_i <= v;
    do @(posedge clk_i); while (full);
    board.note(v);
    n = gap_len();
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // valid stays high across a burst of writes and drops after the last one
  task automatic write_reg(cfg_idx_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, d);
  endtask

  // wait until every run is out, then let a zero-length span finish too
  task automatic settle();
    push <= 1'b0;
    while (board.run_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] ss, logic [31:0] ts, logic [31:0] zs,
                           logic [31:0] sb, logic [31:0] tbv, logic [31:0] sl,
                           logic [31:0] tl, logic [31:0] rp);
    write_reg(CFG_S_STEP, ss);
    write_reg(CFG_T_STEP, ts);
    write_reg(CFG_IZ_STEP, zs);
    write_reg(CFG_S_BIAS, sb);
    write_reg(CFG_T_BIAS, tbv);
    write_reg(CFG_S_LIMIT, sl);
    write_reg(CFG_T_LIMIT, tl);
    write_reg(CFG_ROW_PITCH, rp);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t mk(int x, int y, int len, logic [31:0] s, logic [31:0] t,
                             logic [31:0] iz);
    in_t v;
    v.start_x = 10'(x); v.start_y = 10'(y); v.span_len = 11'(len);
    v.s_over_z_start = s; v.t_over_z_start = t; v.inv_z_start = iz;
    return v;
  endfunction

  function automatic logic [31:0] small_signed(int bits);
    return 32'($urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1)));
  endfunction

  function automatic in_t rand_span(bit plain);
    in_t v;
    int  p;
    v.start_x = 10'($urandom);
    v.start_y = 10'($urandom);
    p = $urandom_range(0, 99);
    if (p < 70) v.span_len = 11'($urandom_range(1, 40));
    else if (p < 96) v.span_len = 11'($urandom_range(41, 200));
    else v.span_len = 11'($urandom_range(201, 2047));
    if ($urandom_range(0, 49) == 0) v.span_len = '0;
    if (plain) begin
      v.s_over_z_start = small_signed(27);
      v.t_over_z_start = small_signed(27);
      v.inv_z_start    = $urandom_range(32'h0400_0000, 32'hC000_0000);
    end else begin
      v.s_over_z_start = $urandom;
      v.t_over_z_start = $urandom;
      v.inv_z_start    = $urandom_range(1, 32'hFFFF_FFFF);
    end
    return v;
  endfunction

  initial begin : sender
    bit plain;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: limits zero so every coordinate clamps to zero
    send_span(mk(5, 7, 20, 32'h0001_0000, 32'h0002_0000, 32'h4000_0000));
    send_span(mk(0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1));
    settle();

    write_all(32'h0000_1000, 32'hFFFF_F800, 32'h0000_0100, 32'd0, 32'd0,
              32'h00FF_FFFF, 32'h00FF_FFFF, 32'd640);
    send_span(mk(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h4000_0000));
    send_span(mk(1023, 1023, 1, 32'h0010_0000, 32'h0020_0000, 32'h4000_0000));
    send_span(mk(3, 9, 15, 32'h0010_0000, 32'h0020_0000, 32'h2000_0000));
    send_span(mk(3, 9, 16, 32'h0010_0000, 32'h0020_0000, 32'h2000_0000));
    send_span(mk(3, 9, 17, 32'h0010_0000, 32'h0020_0000, 32'h2000_0000));
    send_span(mk(100, 200, 32, 32'hFFF0_0000, 32'h0020_0000, 32'h1000_0000));
    send_span(mk(512, 511, 1024, 32'h0100_0000, 32'h0100_0000, 32'h8000_0000));
    send_span(mk(1, 2, 2047, 32'h0100_0000, 32'h0100_0000, 32'h8000_0000));
    send_span(mk(0, 1023, 1025, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_span(mk(7, 7, 40, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
    send_span(mk(7, 7, 40, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_7FFF));
    // 1/z walks through zero and wraps
    send_span(mk(20, 30, 48, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_F000));
    send_span(mk(20, 30, 5, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FF00));
    settle();

    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd4096);
    send_span(mk(1023, 1023, 33, 32'h0001_0000, 32'h8000_0000, 32'h0000_0002));
    send_span(mk(0, 1023, 600, 32'h7FFF_FFFF, 32'h0, 32'h4000_0000));
    send_span(mk(1023, 0, 9, 32'h1234_5678, 32'hEDCB_A987, 32'hFFFF_FFFF));
    settle();

    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'd0, 32'h8000_0000, 32'd1);
    send_span(mk(1023, 1023, 31, 32'h4000_0000, 32'hC000_0000, 32'h0000_8000));
    send_span(mk(2, 3, 64, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000));
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      plain = (ph % 2 == 0);
      if (plain)
        write_all(small_signed(18), small_signed(18), small_signed(14),
                  small_signed(20), small_signed(20), $urandom_range(0, 32'h7FFF_FFFF),
                  $urandom_range(32'h0010_0000, 32'h7FFF_FFFF), $urandom_range(1, 4096));
      else
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1, 4096));
      for (int i = 0; i < 75; i++) send_span(rand_span(plain || $urandom_range(0, 3) == 0));
      settle();
    end

    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

### filelist.f
rtl/psrs_pkg.sv
rtl/psrs_div.sv
rtl/psrs_front.sv
rtl/psrs_fifo.sv
rtl/psrs_back.sv
rtl/perspective_span_run_setup.sv
rtl/psrs_checker.sv
tb/sv/tb_top.sv
